FILE: design/hatp_pkg.sv
// Shared payload types and result status codes for the hex TLV parser.
package hatp_pkg;

   localparam logic [2:0] STATUS_VALUE     = 3'd0;
   localparam logic [2:0] STATUS_EMPTY     = 3'd1;
   localparam logic [2:0] STATUS_TRUNCATED = 3'd2;
   localparam logic [2:0] STATUS_BAD_HEX   = 3'd3;
   localparam logic [2:0] STATUS_TOO_WIDE  = 3'd4;

   typedef struct packed {
      logic [7:0] char_in;
      logic       end_of_message;
   } req_payload_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [15:0] element_index;
      logic [15:0] tag_value;
      logic        tag_is_long;
      logic [15:0] value_length;
      logic [7:0]  value_char;
      logic        element_done;
      logic        message_done;
   } rsp_payload_type;

endpackage

FILE: design/hatp_chan_if.sv
// Valid/ready channel carrying one payload beat.
interface hatp_chan_if #(
   parameter type payload_type = logic [7:0]
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

FILE: design/hatp_step.sv
// Parser state register and the per-character decode and result logic.
module hatp_step #(
   parameter int MAX_LENGTH_BYTES = 2
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      advance,
   input  hatp_pkg::req_payload_type item,
   output logic                      result_valid,
   output hatp_pkg::rsp_payload_type result
);

   localparam int LenCntWidth = $clog2(MAX_LENGTH_BYTES + 1);
   localparam logic [7:0] CharLowerF = 8'h66;
   localparam logic [7:0] CharUpperF = 8'h46;

   typedef enum logic [2:0] {
      PH_TAG1   = 3'd0,
      PH_TAG2   = 3'd1,
      PH_TAG3   = 3'd2,
      PH_TAG4   = 3'd3,
      PH_LEN_HI = 3'd4,
      PH_LEN_LO = 3'd5,
      PH_VALUE  = 3'd6
   } phase_type;

   typedef struct packed {
      phase_type              phase;
      logic [15:0]            tag_shift;
      logic                   long_tag;
      logic [3:0]             high_nibble;
      logic [15:0]            length_accum;
      logic [LenCntWidth-1:0] bytes_left;
      logic [16:0]            value_left;
      logic [15:0]            element_count;
      logic                   error_hold;
   } state_type;

   // bit 4 set marks a non-hex character
   function automatic logic [4:0] hex_decode(input logic [7:0] c);
      logic [4:0] r;
      r = 5'h10;
      if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b0, c[3:0]};
      end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
         r = {1'b0, 4'(c[3:0] + 4'd9)};
      end
      return r;
   endfunction

   state_type   state_ff, state_in, state_clear, snap;
   logic [4:0]  hex;
   logic [3:0]  digit;
   logic        is_hex, eom;
   logic [7:0]  len_byte;
   logic        fail, len_done, handled;
   logic [2:0]  fail_code;
   logic        emit_en, emit_edone, emit_mdone;
   logic [2:0]  emit_status;
   logic [7:0]  emit_char;

   assign state_clear = '{PH_TAG1, 16'h0, 1'b0, 4'h0, 16'h0, '0, 17'h0, 16'h0, 1'b0};
   assign hex      = hex_decode(item.char_in);
   assign digit    = hex[3:0];
   assign is_hex   = !hex[4];
   assign eom      = item.end_of_message;
   assign len_byte = {state_ff.high_nibble, digit};

   always_comb begin
      state_in    = state_ff;
      snap        = state_ff;
      fail        = 1'b0;
      fail_code   = hatp_pkg::STATUS_BAD_HEX;
      len_done    = 1'b0;
      handled     = 1'b0;
      emit_en     = 1'b0;
      emit_status = hatp_pkg::STATUS_VALUE;
      emit_char   = 8'h0;
      emit_edone  = 1'b0;
      emit_mdone  = 1'b0;
      if (state_ff.error_hold) begin
         // drop characters until the message ends
         if (eom) begin
            state_in = state_clear;
         end
      end else begin
         unique case (state_ff.phase)
            PH_TAG2: begin
               if (!is_hex) begin
                  fail = 1'b1;
               end else begin
                  state_in.tag_shift = {state_ff.tag_shift[11:0], digit};
                  if (item.char_in == CharLowerF || item.char_in == CharUpperF) begin
                     state_in.long_tag = 1'b1;
                     state_in.phase    = PH_TAG3;
                  end else begin
                     state_in.phase = PH_LEN_HI;
                  end
               end
            end
            PH_TAG3, PH_TAG4: begin
               if (!is_hex) begin
                  fail = 1'b1;
               end else begin
                  state_in.tag_shift = {state_ff.tag_shift[11:0], digit};
                  state_in.phase     = (state_ff.phase == PH_TAG3) ? PH_TAG4 : PH_LEN_HI;
               end
            end
            PH_LEN_HI: begin
               if (!is_hex) begin
                  fail = 1'b1;
               end else begin
                  state_in.high_nibble = digit;
                  state_in.phase       = PH_LEN_LO;
               end
            end
            PH_LEN_LO: begin
               if (!is_hex) begin
                  fail = 1'b1;
               end else if (state_ff.bytes_left == '0) begin
                  if (!len_byte[7]) begin
                     state_in.length_accum = {8'h0, len_byte};
                     len_done              = 1'b1;
                  end else if (int'(len_byte[6:0]) > MAX_LENGTH_BYTES) begin
                     fail      = 1'b1;
                     fail_code = hatp_pkg::STATUS_TOO_WIDE;
                  end else begin
                     state_in.length_accum = 16'h0;
                     if (len_byte[6:0] == 7'h0) begin
                        len_done = 1'b1;
                     end else begin
                        state_in.bytes_left = LenCntWidth'(len_byte[6:0]);
                        state_in.phase      = PH_LEN_HI;
                     end
                  end
               end else if (state_ff.length_accum[15:8] != 8'h0) begin
                  fail      = 1'b1;
                  fail_code = hatp_pkg::STATUS_TOO_WIDE;
               end else begin
                  state_in.length_accum = {state_ff.length_accum[7:0], len_byte};
                  state_in.bytes_left   = state_ff.bytes_left - LenCntWidth'(1);
                  if (state_in.bytes_left == '0) begin
                     len_done = 1'b1;
                  end else begin
                     state_in.phase = PH_LEN_HI;
                  end
               end
            end
            PH_VALUE: begin
               handled = 1'b1;
               if (state_ff.value_left <= 17'd1) begin
                  emit_en           = 1'b1;
                  emit_char         = item.char_in;
                  emit_edone        = 1'b1;
                  emit_mdone        = eom;
                  state_in.value_left = 17'h0;
                  state_in.phase    = PH_TAG1;
                  if (eom) begin
                     state_in = state_clear;
                  end
               end else begin
                  state_in.value_left = state_ff.value_left - 17'd1;
                  if (!eom) begin
                     emit_en   = 1'b1;
                     emit_char = item.char_in;
                  end else begin
                     handled = 1'b0;
                  end
               end
            end
            default: begin
               // first tag character opens a new element
               if (state_ff.element_count != 16'hFFFF) begin
                  state_in.element_count = state_ff.element_count + 16'd1;
               end
               state_in.tag_shift    = 16'h0;
               state_in.long_tag     = 1'b0;
               state_in.high_nibble  = 4'h0;
               state_in.length_accum = 16'h0;
               state_in.bytes_left   = '0;
               state_in.value_left   = 17'h0;
               state_in.phase        = PH_TAG2;
               if (!is_hex) begin
                  fail = 1'b1;
               end else begin
                  state_in.tag_shift = {12'h0, digit};
               end
            end
         endcase

         if (fail) begin
            emit_en     = 1'b1;
            emit_status = fail_code;
            emit_edone  = 1'b1;
            emit_mdone  = eom;
            snap        = state_in;
            if (eom) begin
               state_in = state_clear;
            end else begin
               state_in.error_hold = 1'b1;
            end
         end else if (!handled) begin
            if (len_done) begin
               if (state_in.length_accum == 16'h0) begin
                  emit_en     = 1'b1;
                  emit_status = hatp_pkg::STATUS_EMPTY;
                  emit_edone  = 1'b1;
                  emit_mdone  = eom;
                  snap        = state_in;
                  handled     = 1'b1;
                  state_in.phase = PH_TAG1;
                  if (eom) begin
                     state_in = state_clear;
                  end
               end else begin
                  state_in.value_left = {state_in.length_accum, 1'b0};
                  state_in.phase      = PH_VALUE;
               end
            end
            if (!handled && eom) begin
               emit_en     = 1'b1;
               emit_status = hatp_pkg::STATUS_TRUNCATED;
               emit_edone  = 1'b1;
               emit_mdone  = 1'b1;
               snap        = state_in;
               state_in    = state_clear;
            end
         end
      end
   end

   always_comb begin
      result_valid         = emit_en;
      result.status        = emit_status;
      result.element_index = snap.element_count;
      result.tag_value     = snap.tag_shift;
      result.tag_is_long   = snap.long_tag;
      result.value_length  = snap.length_accum;
      result.value_char    = emit_char;
      result.element_done  = emit_edone;
      result.message_done  = emit_mdone;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= state_clear;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: design/hex_ascii_tlv_parser_unit.sv
// Top level of the hex TLV parser: input register, decode step, result register.
//
//   channel   dir   payload                                    beat
//   req_chan  in    char_in, end_of_message                    one character
//   rsp_chan  out   status, index, tag, length, char, flags    zero or one per character
//
// A character is decoded once it waits in the input register and the result
// register can take a beat; its result shows on rsp_chan in the next cycle.
// One character per clock is sustained while rsp_chan.ready stays high; the
// limit is the single decode step per cycle. A stalled result holds the
// decode step and, once the input register is full, req_chan.ready. Reset
// is synchronous and clears parser state and both valid flags.
module hex_ascii_tlv_parser_unit #(
   parameter int MAX_LENGTH_BYTES = 2
) (
   input logic         clock,
   input logic         reset,
   hatp_chan_if.sink   req_chan,
   hatp_chan_if.source rsp_chan
);

   logic                      in_valid_ff, in_valid_in;
   hatp_pkg::req_payload_type in_item_ff;
   logic                      rsp_valid_ff, rsp_valid_in;
   hatp_pkg::rsp_payload_type rsp_item_ff;
   logic                      advance, req_take;
   logic                      step_valid;
   hatp_pkg::rsp_payload_type step_result;

   // decode when a character waits and the result register can take a beat
   assign advance  = in_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;
   assign req_take = req_chan.valid && req_chan.ready;

   assign in_valid_in  = req_take ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign rsp_valid_in = advance ? step_valid : (rsp_valid_ff && !rsp_chan.ready);

   hatp_step #(
      .MAX_LENGTH_BYTES (MAX_LENGTH_BYTES)
   ) u_step (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .item         (in_item_ff),
      .result_valid (step_valid),
      .result       (step_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (req_take) begin
         in_item_ff <= req_chan.payload;
      end
      if (advance) begin
         rsp_item_ff <= step_result;
      end
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_item_ff;

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid_ff && !in_valid_ff)
      else $error("valid flags not cleared by reset");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_chan.ready |=> rsp_valid_ff && $stable(rsp_item_ff))
      else $error("stalled result lost or changed");

   a_marker_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_item_ff.status != hatp_pkg::STATUS_VALUE
      |-> rsp_item_ff.element_done && rsp_item_ff.value_char == 8'h0)
      else $error("marker or error beat with value char or open element");

   a_open_char_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_item_ff.element_done |-> !rsp_item_ff.message_done)
      else $error("message ended inside an element");

   a_index_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_item_ff.element_index != 16'h0)
      else $error("result without an element");

endmodule

FILE: tb/hex_ascii_tlv_parser_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the hex TLV parser: predicts result beats, drives random messages.
module hex_ascii_tlv_parser_unit_tb;

   localparam int MAX_LEN_BYTES    = 2;
   localparam int ITEM_TARGET      = 1040;
   localparam int QUIET_ITEMS      = 150;
   localparam int HOLD_AT_ITEMS    = 300;
   localparam int DRAIN_AT_ITEMS   = 600;
   localparam int LONG_HOLD_CYCLES = 200;
   localparam int TAIL_CYCLES      = 20;
   localparam int CYCLE_LIMIT      = 400000;

   typedef enum logic [2:0] {
      PH_TAG_FIRST,
      PH_TAG_SECOND,
      PH_TAG_THIRD,
      PH_TAG_FOURTH,
      PH_LEN_HIGH,
      PH_LEN_LOW,
      PH_VALUE
   } parse_phase_type;

   class tlv_checker;
      parse_phase_type           phase;
      logic [15:0]               tag_shift;
      logic                      long_tag;
      logic [3:0]                high_nib;
      logic [15:0]               len_accum;
      logic [2:0]                len_left;
      logic [16:0]               chars_left;
      logic [15:0]               elem_count;
      bit                        err_hold;
      hatp_pkg::rsp_payload_type awaited[$];
      int                        errors;
      int                        live_chars;

      function new();
         clear_parse();
         errors     = 0;
         live_chars = 0;
      endfunction

      function void clear_parse();
         phase      = PH_TAG_FIRST;
         tag_shift  = '0;
         long_tag   = 1'b0;
         high_nib   = '0;
         len_accum  = '0;
         len_left   = '0;
         chars_left = '0;
         elem_count = '0;
         err_hold   = 1'b0;
      endfunction

      function void push_result(logic [2:0] status, logic [7:0] vchar, logic edone, logic mdone);
         hatp_pkg::rsp_payload_type r;
         r.status        = status;
         r.element_index = elem_count;
         r.tag_value     = tag_shift;
         r.tag_is_long   = long_tag;
         r.value_length  = len_accum;
         r.value_char    = vchar;
         r.element_done  = edone;
         r.message_done  = mdone;
         awaited.push_back(r);
      endfunction

      function void flag_error(logic [2:0] code, logic eom);
         push_result(code, 8'h00, 1'b1, eom);
         if (eom) clear_parse();
         else err_hold = 1'b1;
      endfunction

      function void take_char(hatp_pkg::req_payload_type beat);
         logic [7:0] ch;
         logic       eom;
         logic [4:0] digit;
         logic [7:0] len_byte;
         logic [7:0] n;
         bit         len_done;
         ch       = beat.char_in;
         eom      = beat.end_of_message;
         len_done = 1'b0;
         live_chars++;
         if (ch >= "0" && ch <= "9")
            digit = {1'b0, ch[3:0]};
         else if ((ch >= "a" && ch <= "f") || (ch >= "A" && ch <= "F"))
            digit = {1'b0, ch[3:0] + 4'd9};
         else
            digit = 5'd16;

         // drop everything up to the end of an errored message
         if (err_hold) begin
            if (eom) clear_parse();
            return;
         end

         case (phase)
            PH_TAG_SECOND: begin
               if (digit[4]) begin
                  flag_error(hatp_pkg::STATUS_BAD_HEX, eom);
                  return;
               end
               tag_shift = {tag_shift[11:0], digit[3:0]};
               if (ch == "f" || ch == "F") begin
                  long_tag = 1'b1;
                  phase    = PH_TAG_THIRD;
               end else begin
                  phase = PH_LEN_HIGH;
               end
            end
            PH_TAG_THIRD, PH_TAG_FOURTH: begin
               if (digit[4]) begin
                  flag_error(hatp_pkg::STATUS_BAD_HEX, eom);
                  return;
               end
               tag_shift = {tag_shift[11:0], digit[3:0]};
               if (phase == PH_TAG_THIRD) phase = PH_TAG_FOURTH;
               else phase = PH_LEN_HIGH;
            end
            PH_LEN_HIGH: begin
               if (digit[4]) begin
                  flag_error(hatp_pkg::STATUS_BAD_HEX, eom);
                  return;
               end
               high_nib = digit[3:0];
               phase    = PH_LEN_LOW;
            end
            PH_LEN_LOW: begin
               if (digit[4]) begin
                  flag_error(hatp_pkg::STATUS_BAD_HEX, eom);
                  return;
               end
               len_byte = {high_nib, digit[3:0]};
               if (len_left == 3'd0) begin
                  if (!len_byte[7]) begin
                     len_accum = {8'h00, len_byte};
                     len_done  = 1'b1;
                  end else begin
                     n = len_byte - 8'h80;
                     if (n > MAX_LEN_BYTES) begin
                        flag_error(hatp_pkg::STATUS_TOO_WIDE, eom);
                        return;
                     end
                     len_accum = '0;
                     if (n == 8'd0) begin
                        len_done = 1'b1;
                     end else begin
                        len_left = n[2:0];
                        phase    = PH_LEN_HIGH;
                     end
                  end
               end else begin
                  // another byte would push the length past 16 bits
                  if (len_accum > 16'h00FF) begin
                     flag_error(hatp_pkg::STATUS_TOO_WIDE, eom);
                     return;
                  end
                  len_accum = {len_accum[7:0], len_byte};
                  len_left  = len_left - 3'd1;
                  if (len_left == 3'd0) len_done = 1'b1;
                  else phase = PH_LEN_HIGH;
               end
            end
            PH_VALUE: begin
               if (chars_left <= 17'd1) begin
                  push_result(hatp_pkg::STATUS_VALUE, ch, 1'b1, eom);
                  chars_left = '0;
                  phase      = PH_TAG_FIRST;
                  if (eom) clear_parse();
                  return;
               end
               chars_left = chars_left - 17'd1;
               if (!eom) begin
                  push_result(hatp_pkg::STATUS_VALUE, ch, 1'b0, 1'b0);
                  return;
               end
            end
            default: begin
               if (elem_count != 16'hFFFF) elem_count++;
               tag_shift  = '0;
               long_tag   = 1'b0;
               high_nib   = '0;
               len_accum  = '0;
               len_left   = '0;
               chars_left = '0;
               phase      = PH_TAG_SECOND;
               if (digit[4]) begin
                  flag_error(hatp_pkg::STATUS_BAD_HEX, eom);
                  return;
               end
               tag_shift = {12'h000, digit[3:0]};
            end
         endcase

         if (len_done) begin
            if (len_accum == 16'd0) begin
               push_result(hatp_pkg::STATUS_EMPTY, 8'h00, 1'b1, eom);
               phase = PH_TAG_FIRST;
               if (eom) clear_parse();
               return;
            end
            chars_left = {len_accum, 1'b0};
            phase      = PH_VALUE;
         end

         if (eom) begin
            push_result(hatp_pkg::STATUS_TRUNCATED, 8'h00, 1'b1, 1'b1);
            clear_parse();
         end
      endfunction

      function void match_result(hatp_pkg::rsp_payload_type got);
         hatp_pkg::rsp_payload_type want;
         if (awaited.size() == 0) begin
            $error("result beat with none awaited: status %0d, value_char %0h",
                   got.status, got.value_char);
            errors++;
            return;
         end
         want = awaited.pop_front();
         if (got.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, got.status);
            errors++;
         end
         if (got.element_index !== want.element_index) begin
            $error("element_index: expected %0d, actual %0d", want.element_index,
                   got.element_index);
            errors++;
         end
         if (got.tag_value !== want.tag_value) begin
            $error("tag_value: expected %0h, actual %0h", want.tag_value, got.tag_value);
            errors++;
         end
         if (got.tag_is_long !== want.tag_is_long) begin
            $error("tag_is_long: expected %0d, actual %0d", want.tag_is_long, got.tag_is_long);
            errors++;
         end
         if (got.value_length !== want.value_length) begin
            $error("value_length: expected %0d, actual %0d", want.value_length,
                   got.value_length);
            errors++;
         end
         if (got.value_char !== want.value_char) begin
            $error("value_char: expected %0h, actual %0h", want.value_char, got.value_char);
            errors++;
         end
         if (got.element_done !== want.element_done) begin
            $error("element_done: expected %0d, actual %0d", want.element_done,
                   got.element_done);
            errors++;
         end
         if (got.message_done !== want.message_done) begin
            $error("message_done: expected %0d, actual %0d", want.message_done,
                   got.message_done);
            errors++;
         end
      endfunction

      function int pending();
         return awaited.size();
      endfunction
   endclass

   logic        clock;
   logic        reset;
   tlv_checker  board;
   logic [7:0]  msg_chars[$];
   bit          quiet;
   bit          hold_request;
   int unsigned cycle_count = 0;

   hatp_chan_if #(.payload_type(hatp_pkg::req_payload_type)) req_if ();
   hatp_chan_if #(.payload_type(hatp_pkg::rsp_payload_type)) rsp_if ();

   hex_ascii_tlv_parser_unit #(
      .MAX_LENGTH_BYTES(MAX_LEN_BYTES)
   ) u_top (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_if),
      .rsp_chan(rsp_if)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // Sample mid-cycle; both sides only change at the rising edge.
   always @(negedge clock) begin
      if (reset === 1'b0) begin
         if (req_if.valid && req_if.ready) board.take_char(req_if.payload);
         if (rsp_if.valid && rsp_if.ready) board.match_result(rsp_if.payload);
      end
   end

   initial begin
      rsp_if.ready = 1'b0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         if (hold_request) begin
            // hold off long enough for the input side to back up
            hold_request = 1'b0;
            rsp_if.ready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
         end else if (!quiet && $urandom_range(0, 3) == 0) begin
            rsp_if.ready <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clock);
         end else begin
            rsp_if.ready <= 1'b1;
            if (quiet) @(posedge clock);
            else repeat ($urandom_range(1, 16)) @(posedge clock);
         end
      end
   end

   task automatic send_beat(input logic [7:0] ch, input logic eom);
      bit taken;
      req_if.valid   <= 1'b1;
      req_if.payload <= '{char_in: ch, end_of_message: eom};
      do begin
         @(negedge clock);
         taken = req_if.ready;
         @(posedge clock);
      end while (!taken);
      if (!quiet && $urandom_range(0, 4) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
   endtask

   task automatic flush_message();
      for (int i = 0; i < msg_chars.size(); i++)
         send_beat(msg_chars[i], i == msg_chars.size() - 1);
      msg_chars.delete();
   endtask

   function automatic void add_text(input string s);
      for (int i = 0; i < s.len(); i++) msg_chars.push_back(s[i]);
   endfunction

   // Append one byte as two hex characters, letters in random case.
   function automatic void add_hex_byte(input logic [7:0] b);
      logic [3:0] nib;
      for (int k = 1; k >= 0; k--) begin
         nib = b[4*k +: 4];
         if (nib < 4'd10) msg_chars.push_back("0" + nib);
         else if ($urandom_range(0, 1) != 0) msg_chars.push_back("a" + nib - 8'd10);
         else msg_chars.push_back("A" + nib - 8'd10);
      end
   endfunction

   function automatic void add_element();
      logic [7:0] tag_hi;
      int         len;
      tag_hi = 8'($urandom);
      if ($urandom_range(0, 3) == 0) begin
         tag_hi[3:0] = 4'hF;
         add_hex_byte(tag_hi);
         add_hex_byte(8'($urandom));
      end else begin
         if (tag_hi[3:0] == 4'hF) tag_hi[3:0] = 4'hE;
         add_hex_byte(tag_hi);
      end
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 24) : $urandom_range(0, 5);
      case ($urandom_range(0, 4))
         0, 1: add_hex_byte(len[7:0]);
         2: begin
            add_hex_byte(8'h81);
            add_hex_byte(len[7:0]);
         end
         3: begin
            add_hex_byte(8'h82);
            add_hex_byte(8'h00);
            add_hex_byte(len[7:0]);
         end
         default: begin
            if (len == 0) add_hex_byte(8'h80);
            else add_hex_byte(len[7:0]);
         end
      endcase
      repeat (2 * len) msg_chars.push_back(8'($urandom_range(0, 255)));
   endfunction

   function automatic void add_random_message();
      int         kind;
      int         cut;
      int         spot;
      logic [7:0] junk;
      kind = $urandom_range(0, 9);
      if (kind <= 8) repeat ($urandom_range(1, 4)) add_element();
      case (kind)
         7: begin
            // end the message early
            cut = $urandom_range(1, msg_chars.size() - 1);
            while (msg_chars.size() > cut) void'(msg_chars.pop_back());
         end
         8: begin
            spot = $urandom_range(0, msg_chars.size() - 1);
            do begin
               junk = 8'($urandom);
            end while ((junk >= "0" && junk <= "9") || (junk >= "a" && junk <= "f") ||
                       (junk >= "A" && junk <= "F"));
            msg_chars[spot] = junk;
         end
         9: begin
            junk = 8'($urandom);
            if (junk[3:0] == 4'hF) junk[3:0] = 4'h0;
            add_hex_byte(junk);
            case ($urandom_range(0, 3))
               0: add_hex_byte(8'($urandom_range(8'h83, 8'hFF)));
               1: add_hex_byte(8'h7F);
               2: begin
                  add_hex_byte(8'h82);
                  add_hex_byte(8'($urandom));
                  add_hex_byte(8'($urandom));
               end
               default: begin
                  add_hex_byte(8'h82);
                  add_hex_byte(8'hFF);
                  add_hex_byte(8'hFF);
               end
            endcase
            repeat ($urandom_range(0, 8)) msg_chars.push_back(8'($urandom_range(0, 255)));
         end
         default: ;
      endcase
   endfunction

   initial begin
      bit hold_done;
      bit drain_done;
      board          = new();
      hold_done      = 1'b0;
      drain_done     = 1'b0;
      quiet          = 1'b0;
      hold_request   = 1'b0;
      reset          = 1'b1;
      req_if.valid   = 1'b0;
      req_if.payload = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // short tag with an empty element
      add_text("0100");
      flush_message();
      // four-character tag, zero long form
      add_text("9f1F80");
      flush_message();
      // two value characters at the byte extremes
      add_text("0A01");
      msg_chars.push_back(8'hFF);
      msg_chars.push_back(8'h00);
      flush_message();
      // bad hex in the first tag character, then ignored until the end
      add_text("Gx");
      flush_message();
      // too many length bytes
      add_text("0183");
      flush_message();
      // message ends after the tag, before the length
      add_text("01");
      flush_message();

      while (board.live_chars < ITEM_TARGET) begin
         if (!hold_done && board.live_chars >= HOLD_AT_ITEMS) begin
            hold_request = 1'b1;
            hold_done    = 1'b1;
         end
         if (!drain_done && board.live_chars >= DRAIN_AT_ITEMS) begin
            // pause until every awaited result is out
            req_if.valid <= 1'b0;
            do @(posedge clock); while (board.pending() != 0);
            drain_done = 1'b1;
         end
         if (board.live_chars >= ITEM_TARGET - QUIET_ITEMS) quiet = 1'b1;
         add_random_message();
         flush_message();
      end
      req_if.valid <= 1'b0;

      while (board.pending() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (board.errors == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

FILE: sim.f
design/hatp_pkg.sv
design/hatp_chan_if.sv
design/hatp_step.sv
design/hex_ascii_tlv_parser_unit.sv
tb/hex_ascii_tlv_parser_unit_tb.sv
